>>> sv/cdte_pkg.sv
// ----------------------------------------------------------------------------
// cdte_pkg
// Shared types, constants and the month length table for the calendar date
// to epoch seconds converter.
// ----------------------------------------------------------------------------
package cdte_pkg;

	// The epoch year and the last year that the converter accepts.
	localparam int BASE_YEAR_VALUE = 1970;
	localparam int LAST_YEAR_VALUE = 2105;

	localparam int YEAR_W = 12;
	localparam int DAYS_W = 17;
	localparam int SEC_W  = 32;
	localparam int TOD_W  = 17;

	localparam logic [YEAR_W-1:0] BASE_YEAR = YEAR_W'(BASE_YEAR_VALUE);
	localparam logic [YEAR_W-1:0] LAST_YEAR = YEAR_W'(LAST_YEAR_VALUE);

	// Starting phases of the leap year counters.
	localparam logic [1:0] EPOCH_MOD4   = 2'(BASE_YEAR_VALUE % 4);
	localparam logic [6:0] EPOCH_MOD100 = 7'(BASE_YEAR_VALUE % 100);
	localparam logic [8:0] EPOCH_MOD400 = 9'(BASE_YEAR_VALUE % 400);

	localparam logic [DAYS_W-1:0] SECS_PER_DAY    = DAYS_W'(86400);
	localparam logic [11:0]       SECS_PER_HOUR   = 12'd3600;
	localparam logic [5:0]        SECS_PER_MINUTE = 6'd60;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic year_step;
		logic month_step;
		logic mul;
		logic sum;
	} cdte_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic invalid;
		logic year_done;
		logic month_done;
	} cdte_status_t;

	// Length of month idx (0 is January) for a common or a leap year.
	function automatic logic [4:0] month_days(input logic leap, input logic [3:0] idx);
		logic [4:0] d;
		unique case (idx)
			4'd1:                      d = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
			default:                   d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

>>> sv/cdte_ctrl.sv
// ----------------------------------------------------------------------------
// cdte_ctrl
// Sequencer for the converter: walks the years, then the earlier months,
// then scales and sums, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module cdte_ctrl
	import cdte_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  cdte_status_t status,
	output cdte_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_YEARS  = 3'd1;
	localparam logic [2:0] ST_MONTHS = 3'd2;
	localparam logic [2:0] ST_MUL    = 3'd3;
	localparam logic [2:0] ST_SUM    = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_YEARS;
				end
			end
			ST_YEARS: begin
				// An invalid request skips the walk; the sum step forces zero.
				if (status.invalid) begin
					state_d = ST_SUM;
				end else if (status.year_done) begin
					state_d = ST_MONTHS;
				end else begin
					cmd.year_step = 1'b1;
				end
			end
			ST_MONTHS: begin
				if (status.month_done) begin
					state_d = ST_MUL;
				end else begin
					cmd.month_step = 1'b1;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/cdte_dp.sv
// ----------------------------------------------------------------------------
// cdte_dp
// Datapath: input capture and range check, year and month day accumulator
// with running leap year counters, day scaling and time of day sum.
// ----------------------------------------------------------------------------
module cdte_dp
	import cdte_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cdte_cmd_t         cmd,
	output cdte_status_t      status,
	input  logic [4:0]        hour,
	input  logic [5:0]        minute,
	input  logic [5:0]        second,
	input  logic [4:0]        day_of_month,
	input  logic [3:0]        month,
	input  logic [YEAR_W-1:0] year,
	output logic [SEC_W-1:0]  epoch_seconds,
	output logic              invalid
);

	logic [4:0]        hour_q;
	logic [5:0]        minute_q;
	logic [5:0]        second_q;
	logic [3:0]        month_q;
	logic [YEAR_W-1:0] year_q;
	logic              invalid_q;

	logic [YEAR_W-1:0] y_q;
	logic [1:0]        c4_q;
	logic [6:0]        c100_q;
	logic [8:0]        c400_q;
	logic [3:0]        m_q;
	logic [DAYS_W-1:0] days_q;
	logic [SEC_W-1:0]  day_secs_q;
	logic [TOD_W-1:0]  tod_q;
	logic [SEC_W-1:0]  result_q;
	logic              result_invalid_q;

	logic              in_bad;
	logic              leap;
	logic [SEC_W-1:0]  day_prod;
	logic [TOD_W-1:0]  tod_sum;

	assign in_bad = (hour > 5'd23) || (minute > 6'd59) || (second > 6'd59) ||
	                (day_of_month == 5'd0) || (month == 4'd0) || (month > 4'd12) ||
	                (year < BASE_YEAR) || (year > LAST_YEAR);

	// Leap status of the year the counters currently point at.
	assign leap = (c4_q == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));

	assign status.invalid    = invalid_q;
	assign status.year_done  = (y_q == year_q);
	assign status.month_done = ((m_q + 4'd1) == month_q);

	assign day_prod = SEC_W'(days_q) * SEC_W'(SECS_PER_DAY);
	assign tod_sum  = TOD_W'(hour_q) * TOD_W'(SECS_PER_HOUR) +
	                  TOD_W'(minute_q) * TOD_W'(SECS_PER_MINUTE) + TOD_W'(second_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hour_q    <= hour;
			minute_q  <= minute;
			second_q  <= second;
			month_q   <= month;
			year_q    <= year;
			invalid_q <= in_bad;
			y_q       <= BASE_YEAR;
			c4_q      <= EPOCH_MOD4;
			c100_q    <= EPOCH_MOD100;
			c400_q    <= EPOCH_MOD400;
			m_q       <= 4'd0;
			// The days before today seed the accumulator.
			days_q    <= DAYS_W'(day_of_month - 5'd1);
		end
		if (cmd.year_step) begin
			days_q <= days_q + (leap ? DAYS_W'(366) : DAYS_W'(365));
			y_q    <= y_q + YEAR_W'(1);
			c4_q   <= c4_q + 2'd1;
			c100_q <= (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
			c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
		end
		if (cmd.month_step) begin
			days_q <= days_q + DAYS_W'(month_days(leap, m_q));
			m_q    <= m_q + 4'd1;
		end
		if (cmd.mul) begin
			day_secs_q <= day_prod;
			tod_q      <= tod_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_q         <= '0;
			result_invalid_q <= 1'b0;
		end else if (cmd.sum) begin
			result_q         <= invalid_q ? '0 : day_secs_q + SEC_W'(tod_q);
			result_invalid_q <= invalid_q;
		end
	end

	assign epoch_seconds = result_q;
	assign invalid       = result_invalid_q;

endmodule

>>> sv/calendar_date_to_epoch_seconds.sv
// The time to a result grows with the year and month of the request: the
// sequencer walks the years serially, then the earlier months, while an
// invalid request skips both walks. One request is in flight at a time; the
// next is taken no earlier than the cycle after the result leaves.
// Reset (arst_n, asynchronous, active low) returns the sequencer to idle.
// ----------------------------------------------------------------------------
// calendar_date_to_epoch_seconds
// Converts a calendar date and time of day into seconds since the epoch.
// ----------------------------------------------------------------------------
module calendar_date_to_epoch_seconds
	import cdte_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [4:0]        hour,
	input  logic [5:0]        minute,
	input  logic [5:0]        second,
	input  logic [4:0]        day_of_month,
	input  logic [3:0]        month,
	input  logic [YEAR_W-1:0] year,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SEC_W-1:0]  epoch_seconds,
	output logic              invalid
);

	cdte_cmd_t    cmd;
	cdte_status_t status;

	cdte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	cdte_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.day_of_month  (day_of_month),
		.month         (month),
		.year          (year),
		.epoch_seconds (epoch_seconds),
		.invalid       (invalid)
	);

`ifndef SYNTHESIS
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("result shown while idle");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && invalid) |-> (epoch_seconds == '0))
		else $error("invalid result carries nonzero seconds");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request accepted while busy");
`endif

endmodule

>>> tb/tb_calendar_date_to_epoch_seconds.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_calendar_date_to_epoch_seconds
// Drives dates and times of day into the converter through the request
// channel and checks every returned epoch_seconds and invalid flag against
// a predictor that counts days year by year and month by month. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_calendar_date_to_epoch_seconds;
	import cdte_pkg::*;

	localparam int STALL_LIMIT   = 5000;
	localparam int DRAIN_CYCLES  = 200;
	localparam int RANDOM_COUNT  = 1000;
	localparam int HOLD_OFF_LEN  = 400;
	localparam int HOLD_OFF_AT   = 60;

	typedef struct {
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second;
		logic [4:0]        day_of_month;
		logic [3:0]        month;
		logic [YEAR_W-1:0] year;
	} date_time_t;

	typedef struct {
		logic [SEC_W-1:0] seconds;
		logic             invalid;
	} conversion_t;

	class epoch_scoreboard;
		conversion_t expected_q[$];
		int          error_count;
		int          results_seen;

		function bit gregorian_leap(int unsigned y);
			return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		endfunction

		function conversion_t seconds_since_epoch(date_time_t dt);
			int unsigned  month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
			conversion_t  c;
			longint unsigned days;
			longint unsigned total;
			bit           leap;
			days = 0;
			if (dt.hour > 23 || dt.minute > 59 || dt.second > 59 || dt.day_of_month == 0 ||
			    dt.month == 0 || dt.month > 12 || dt.year < BASE_YEAR_VALUE ||
			    dt.year > LAST_YEAR_VALUE) begin
				c.seconds = '0;
				c.invalid = 1'b1;
				return c;
			end
			for (int unsigned y = BASE_YEAR_VALUE; y < dt.year; y++)
				days += gregorian_leap(y) ? 366 : 365;
			leap = gregorian_leap(dt.year);
			for (int m = 0; m + 1 < dt.month; m++)
				days += month_len[m] + ((m == 1 && leap) ? 1 : 0);
			days += dt.day_of_month - 1;
			total = days * 86400 + dt.hour * 3600 + dt.minute * 60 + dt.second;
			c.seconds = total[SEC_W-1:0];
			c.invalid = 1'b0;
			return c;
		endfunction

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			error_count++;
		endtask

		function void note_request(date_time_t dt);
			expected_q.push_back(seconds_since_epoch(dt));
		endfunction

		task check_result(logic [SEC_W-1:0] seconds, logic inv);
			conversion_t exp_c;
			results_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result %0d / %0b with no request pending",
					seconds, inv));
				return;
			end
			exp_c = expected_q.pop_front();
			if (seconds !== exp_c.seconds)
				report_mismatch($sformatf("epoch_seconds %0d, expected %0d",
					seconds, exp_c.seconds));
			if (inv !== exp_c.invalid)
				report_mismatch($sformatf("invalid %0b, expected %0b", inv, exp_c.invalid));
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [4:0]        hour;
	logic [5:0]        minute;
	logic [5:0]        second;
	logic [4:0]        day_of_month;
	logic [3:0]        month;
	logic [YEAR_W-1:0] year;
	logic              out_valid;
	logic              out_ready;
	logic [SEC_W-1:0]  epoch_seconds;
	logic              invalid;

	epoch_scoreboard sb;
	int sender_idle_pct;
	int receiver_idle_pct;
	int stall_cycles;
	bit hold_off_done;

	calendar_date_to_epoch_seconds u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.day_of_month  (day_of_month),
		.month         (month),
		.year          (year),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.epoch_seconds (epoch_seconds),
		.invalid       (invalid)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Inputs settle at the falling edge; a request holds until it is taken.
	task automatic send_request(input logic [4:0] h, input logic [5:0] mi,
		input logic [5:0] s, input logic [4:0] d, input logic [3:0] mo,
		input logic [YEAR_W-1:0] y);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		hour         <= h;
		minute       <= mi;
		second       <= s;
		day_of_month <= d;
		month        <= mo;
		year         <= y;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Mostly dates with every field in range; the rest break exactly one field.
	task automatic send_random_request();
		logic [4:0]        h;
		logic [5:0]        mi;
		logic [5:0]        s;
		logic [4:0]        d;
		logic [3:0]        mo;
		logic [YEAR_W-1:0] y;
		h  = 5'($urandom_range(23));
		mi = 6'($urandom_range(59));
		s  = 6'($urandom_range(59));
		d  = 5'($urandom_range(31, 1));
		mo = 4'($urandom_range(12, 1));
		// Early years keep the serial year walk short for most requests.
		if ($urandom_range(99) < 70)
			y = YEAR_W'($urandom_range(BASE_YEAR_VALUE + 25, BASE_YEAR_VALUE));
		else
			y = YEAR_W'($urandom_range(LAST_YEAR_VALUE, BASE_YEAR_VALUE));
		if ($urandom_range(99) < 20) begin
			case ($urandom_range(5))
				0: h  = 5'($urandom_range(31, 24));
				1: mi = 6'($urandom_range(63, 60));
				2: s  = 6'($urandom_range(63, 60));
				3: d  = '0;
				4: mo = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 13));
				default: begin
					if ($urandom_range(1))
						y = YEAR_W'($urandom_range(BASE_YEAR_VALUE - 1, 0));
					else
						y = YEAR_W'($urandom_range((1 << YEAR_W) - 1,
							LAST_YEAR_VALUE + 1));
				end
			endcase
		end
		send_request(h, mi, s, d, mo, y);
	endtask

	// Requests are noted after the result check; the converter takes a new
	// request only after the previous result has left.
	always @(posedge clk) begin
		date_time_t dt;
		if (out_valid && out_ready)
			sb.check_result(epoch_seconds, invalid);
		if (in_valid && in_ready) begin
			dt.hour         = hour;
			dt.minute       = minute;
			dt.second       = second;
			dt.day_of_month = day_of_month;
			dt.month        = month;
			dt.year         = year;
			sb.note_request(dt);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_calendar_date_to_epoch_seconds: errors");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off so the request side backs up.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_off_done && sb.results_seen >= HOLD_OFF_AT) begin
				hold_off_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_LEN)
					@(negedge clk);
			end
			out_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	initial begin
		sb = new();
		stall_cycles      = 0;
		hold_off_done     = 1'b0;
		sender_idle_pct   = 34;
		receiver_idle_pct = 46;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		hour         = '0;
		minute       = '0;
		second       = '0;
		day_of_month = 5'd1;
		month        = 4'd1;
		year         = BASE_YEAR;
		repeat (4)
			@(negedge clk);
		arst_n = 1'b1;

		// Epoch start, last accepted instant and the last instant of the epoch year.
		send_request(5'd0, 6'd0, 6'd0, 5'd1, 4'd1, BASE_YEAR);
		send_request(5'd23, 6'd59, 6'd59, 5'd31, 4'd12, LAST_YEAR);
		send_request(5'd23, 6'd59, 6'd59, 5'd31, 4'd12, BASE_YEAR);
		// Leap day in a 400-year century, and a century that is not leap.
		send_request(5'd12, 6'd30, 6'd15, 5'd29, 4'd2, YEAR_W'(2000));
		send_request(5'd0, 6'd0, 6'd0, 5'd1, 4'd3, YEAR_W'(2100));
		send_request(5'd0, 6'd0, 6'd0, 5'd29, 4'd2, YEAR_W'(2100));
		// Days past the end of their month roll into the next month.
		send_request(5'd1, 6'd2, 6'd3, 5'd30, 4'd2, YEAR_W'(2001));
		send_request(5'd1, 6'd2, 6'd3, 5'd31, 4'd2, YEAR_W'(2004));
		send_request(5'd4, 6'd5, 6'd6, 5'd31, 4'd4, YEAR_W'(2038));
		send_request(5'd7, 6'd8, 6'd9, 5'd31, 4'd11, YEAR_W'(2099));
		// Each field just out of range and at its all-ones value; day of month only at zero, month and year also at zero.
		send_request(5'd24, 6'd0, 6'd0, 5'd1, 4'd1, YEAR_W'(2000));
		send_request(5'd31, 6'd0, 6'd0, 5'd1, 4'd1, YEAR_W'(2000));
		send_request(5'd0, 6'd60, 6'd0, 5'd1, 4'd1, YEAR_W'(2000));
		send_request(5'd0, 6'd63, 6'd0, 5'd1, 4'd1, YEAR_W'(2000));
		send_request(5'd0, 6'd0, 6'd60, 5'd1, 4'd1, YEAR_W'(2000));
		send_request(5'd0, 6'd0, 6'd63, 5'd1, 4'd1, YEAR_W'(2000));
		send_request(5'd0, 6'd0, 6'd0, 5'd0, 4'd1, YEAR_W'(2000));
		send_request(5'd0, 6'd0, 6'd0, 5'd1, 4'd0, YEAR_W'(2000));
		send_request(5'd0, 6'd0, 6'd0, 5'd1, 4'd13, YEAR_W'(2000));
		send_request(5'd0, 6'd0, 6'd0, 5'd1, 4'd15, YEAR_W'(2000));
		send_request(5'd0, 6'd0, 6'd0, 5'd1, 4'd1, BASE_YEAR - 1'b1);
		send_request(5'd0, 6'd0, 6'd0, 5'd1, 4'd1, LAST_YEAR + 1'b1);
		send_request(5'd0, 6'd0, 6'd0, 5'd1, 4'd1, '0);
		send_request(5'd0, 6'd0, 6'd0, 5'd1, 4'd1, '1);

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			if (i == RANDOM_COUNT / 3) begin
				sender_idle_pct   = 46;
				receiver_idle_pct = 34;
			end else if (i == 2 * RANDOM_COUNT / 3) begin
				sender_idle_pct   = 0;
				receiver_idle_pct = 0;
			end
			send_random_request();
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (sb.error_count == 0)
			$display("tb_calendar_date_to_epoch_seconds: clean");
		else
			$display("tb_calendar_date_to_epoch_seconds: errors");
		$finish;
	end

endmodule

>>> files.f
sv/cdte_pkg.sv
sv/cdte_ctrl.sv
sv/cdte_dp.sv
sv/calendar_date_to_epoch_seconds.sv
tb/tb_calendar_date_to_epoch_seconds.sv
